>>> rtl/tvfp_pkg.sv
// Shared types and codes for the tag-value field parser.
`default_nettype none
package tvfp_pkg;

  localparam int unsigned ValueCapacityDefault = 32;
  localparam logic [15:0] TypeKeyReset = 16'h4D54;

  localparam logic [7:0] ChStart = 8'h60;
  localparam logic [7:0] ChEnd   = 8'h7E;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChPipe  = 8'h7C;

  localparam logic [2:0] EvNone   = 3'd0;
  localparam logic [2:0] EvByte   = 3'd1;
  localparam logic [2:0] EvField  = 3'd2;
  localparam logic [2:0] EvNewMsg = 3'd3;
  localparam logic [2:0] EvMsgEnd = 3'd4;
  localparam logic [2:0] EvError  = 3'd5;

  // Fixed-width part of one result; the index and length follow the capacity.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  value_byte;
    logic [15:0] field_key;
    logic [15:0] message_type;
    logic        type_known;
  } tvfp_res_t;

endpackage
`default_nettype wire

>>> rtl/tvfp_in_stage.sv
// Input register that holds one received byte until the parser takes it.
`default_nettype none
module tvfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       dn_free,
  output logic            byte_vld,
  output logic [7:0]      byte_q
);
  import tvfp_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_stall = vld_r & ~dn_free;
  assign accept   = in_valid & ~in_stall;
  assign vld_nxt  = accept | (vld_r & ~dn_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_q   = byte_r;

endmodule
`default_nettype wire

>>> rtl/tvfp_parse.sv
// Parse state machine: phase, key, type and value count, one byte per step.
`default_nettype none
module tvfp_parse #(
  parameter int unsigned VALUE_CAPACITY = tvfp_pkg::ValueCapacityDefault,
  localparam int unsigned CntW = $clog2(VALUE_CAPACITY)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_type_key,
  input  wire logic               step,
  input  wire logic [7:0]         rx_byte,
  output tvfp_pkg::tvfp_res_t     res,
  output logic [CntW-1:0]         res_index,
  output logic [CntW-1:0]         res_length
);
  import tvfp_pkg::*;

  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhKeyHi  = 3'd1;
  localparam logic [2:0] PhKeyLo  = 3'd2;
  localparam logic [2:0] PhWaitEq = 3'd3;
  localparam logic [2:0] PhValue  = 3'd4;

  localparam logic [CntW-1:0] CntLast = CntW'(VALUE_CAPACITY - 1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [15:0]     type_key_r;
  logic [2:0]      phase_r, phase_nxt;
  logic [15:0]     key_r, key_nxt;
  logic [15:0]     type_r, type_nxt;
  logic            seen_r, seen_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0]     first_r, first_nxt;
  logic [2:0]      ev;
  logic [7:0]      vbyte;
  logic [CntW-1:0] vidx;
  logic [CntW-1:0] vlen;

  always_comb begin
    phase_nxt = phase_r;
    key_nxt   = key_r;
    type_nxt  = type_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    ev        = EvNone;
    vbyte     = 8'h00;
    vidx      = '0;
    vlen      = '0;
    unique case (phase_r)
      PhHunt: begin
        if (rx_byte == ChStart) begin
          key_nxt   = 16'h0000;
          type_nxt  = 16'h0000;
          seen_nxt  = 1'b0;
          cnt_nxt   = '0;
          phase_nxt = PhKeyHi;
        end
      end
      PhKeyHi: begin
        if (rx_byte == ChEnd) begin
          ev        = EvMsgEnd;
          phase_nxt = PhHunt;
        end else begin
          key_nxt   = {rx_byte, 8'h00};
          phase_nxt = PhKeyLo;
        end
      end
      PhKeyLo: begin
        key_nxt   = {key_r[15:8], rx_byte};
        phase_nxt = PhWaitEq;
      end
      PhWaitEq: begin
        if (rx_byte != ChEq) begin
          ev        = EvError;
          phase_nxt = PhHunt;
        end else begin
          cnt_nxt   = '0;
          first_nxt = 16'h0000;
          phase_nxt = PhValue;
        end
      end
      PhValue: begin
        if (rx_byte == ChPipe) begin
          if (key_r == type_key_r) begin
            type_nxt  = first_r;
            seen_nxt  = 1'b1;
            ev        = EvNewMsg;
            vlen      = cnt_r;
            phase_nxt = PhKeyHi;
          end else if (!seen_r) begin
            // A message must open with its type field.
            ev        = EvError;
            phase_nxt = PhHunt;
          end else begin
            ev        = EvField;
            vlen      = cnt_r;
            phase_nxt = PhKeyHi;
          end
        end else if (cnt_r == CntLast) begin
          ev        = EvError;
          phase_nxt = PhHunt;
        end else begin
          if (cnt_r == '0) begin
            first_nxt = {rx_byte, 8'h00};
          end else if (cnt_r == CntOne) begin
            first_nxt = {first_r[15:8], rx_byte};
          end
          ev      = EvByte;
          vbyte   = rx_byte;
          vidx    = cnt_r;
          cnt_nxt = cnt_r + CntOne;
        end
      end
      default: begin
        phase_nxt = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_key_r <= TypeKeyReset;
      phase_r    <= PhHunt;
      key_r      <= 16'h0000;
      type_r     <= 16'h0000;
      seen_r     <= 1'b0;
      cnt_r      <= '0;
      first_r    <= 16'h0000;
    end else begin
      if (cfg_wr_en) begin
        type_key_r <= cfg_type_key;
      end
      if (step) begin
        phase_r <= phase_nxt;
        key_r   <= key_nxt;
        type_r  <= type_nxt;
        seen_r  <= seen_nxt;
        cnt_r   <= cnt_nxt;
        first_r <= first_nxt;
      end
    end
  end

  always_comb begin
    res.event_res    = ev;
    res.value_byte   = vbyte;
    res.field_key    = key_nxt;
    res.message_type = type_nxt;
    res.type_known   = seen_nxt;
  end

  assign res_index  = vidx;
  assign res_length = vlen;

endmodule
`default_nettype wire

>>> rtl/tvfp_out_stage.sv
// Result register that holds one result until the receiver takes it.
`default_nettype none
module tvfp_out_stage #(
  parameter int unsigned VALUE_CAPACITY = tvfp_pkg::ValueCapacityDefault,
  localparam int unsigned CntW = $clog2(VALUE_CAPACITY)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire tvfp_pkg::tvfp_res_t res,
  input  wire logic [CntW-1:0]     res_index,
  input  wire logic [CntW-1:0]     res_length,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_event_res,
  output logic [7:0]               out_value_byte,
  output logic [CntW-1:0]          out_value_index,
  output logic [CntW-1:0]          out_value_length,
  output logic [15:0]              out_field_key,
  output logic [15:0]              out_message_type,
  output logic                     out_type_known
);
  import tvfp_pkg::*;

  logic            vld_r;
  logic            vld_nxt;
  tvfp_res_t       res_r;
  logic [CntW-1:0] idx_r;
  logic [CntW-1:0] len_r;

  // The register can take a new result when it is empty or being drained.
  assign free    = ~vld_r | ~out_stall;
  assign vld_nxt = load | (vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
      idx_r <= res_index;
      len_r <= res_length;
    end
  end

  assign out_valid        = vld_r;
  assign out_event_res    = res_r.event_res;
  assign out_value_byte   = res_r.value_byte;
  assign out_value_index  = idx_r;
  assign out_value_length = len_r;
  assign out_field_key    = res_r.field_key;
  assign out_message_type = res_r.message_type;
  assign out_type_known   = res_r.type_known;

endmodule
`default_nettype wire

>>> rtl/tag_value_field_parser.sv
// Top level of the tag-value field parser.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    in_rx_byte
//   out      out_valid / out_stall  out_event_res .. out_type_known
//   cfg      cfg_wr_en              cfg_type_key
//
// A byte is parsed while it sits in the input register, and its result is
// then captured in the result register, which drives out_valid; one byte per
// cycle is sustained while out_stall is low, as the parse step is
// combinational.
// Reset is synchronous and active low; it returns the parser to hunting for a
// start mark and restores the type key. A stalled result holds the parser,
// and in_stall rises as soon as the input register holds a byte.
`default_nettype none
module tag_value_field_parser #(
  parameter int unsigned VALUE_CAPACITY = tvfp_pkg::ValueCapacityDefault,
  localparam int unsigned CntW = $clog2(VALUE_CAPACITY)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_type_key,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_value_byte,
  output logic [CntW-1:0]  out_value_index,
  output logic [CntW-1:0]  out_value_length,
  output logic [15:0]      out_field_key,
  output logic [15:0]      out_message_type,
  output logic             out_type_known
);
  import tvfp_pkg::*;

  logic            free;
  logic            byte_vld;
  logic [7:0]      byte_q;
  logic            step;
  tvfp_res_t       res;
  logic [CntW-1:0] res_index;
  logic [CntW-1:0] res_length;

  assign step = byte_vld & free;

  tvfp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .dn_free    (free),
    .byte_vld   (byte_vld),
    .byte_q     (byte_q)
  );

  tvfp_parse #(
    .VALUE_CAPACITY (VALUE_CAPACITY)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_type_key (cfg_type_key),
    .step         (step),
    .rx_byte      (byte_q),
    .res          (res),
    .res_index    (res_index),
    .res_length   (res_length)
  );

  tvfp_out_stage #(
    .VALUE_CAPACITY (VALUE_CAPACITY)
  ) u_out_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (step),
    .res              (res),
    .res_index        (res_index),
    .res_length       (res_length),
    .free             (free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_value_byte   (out_value_byte),
    .out_value_index  (out_value_index),
    .out_value_length (out_value_length),
    .out_field_key    (out_field_key),
    .out_message_type (out_message_type),
    .out_type_known   (out_type_known)
  );

endmodule
`default_nettype wire
